[sv/imuepi_pkg.sv]
package imuepi_pkg;

  localparam int QUAT_FRAC_BITS = 30;
  localparam int STATE_WIDTH = 48;
  localparam int POS_WIDTH = 48;
  localparam int ACC_WIDTH = 64;
  localparam int OPND_WIDTH = STATE_WIDTH + 1;
  localparam int AMAG_WIDTH = STATE_WIDTH;
  localparam int BMAG_WIDTH = 32;
  localparam int PROD_WIDTH = AMAG_WIDTH + BMAG_WIDTH;
  localparam int DIGIT_WIDTH = 4;
  localparam int MUL_STEPS = BMAG_WIDTH / DIGIT_WIDTH;
  localparam int CNT_WIDTH = $clog2(MUL_STEPS);
  localparam int UOP_COUNT = 40;
  localparam int PC_WIDTH = $clog2(UOP_COUNT);
  localparam int SRC_COUNT = 32;

  localparam logic [31:0] DT_RESET = 32'd20452225;
  localparam logic signed [31:0] GZ_RESET = -32'sd642908;
  localparam logic signed [31:0] QUAT_ONE = 32'sd1 <<< QUAT_FRAC_BITS;

  localparam logic signed [ACC_WIDTH-1:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_WIDTH-1:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [ACC_WIDTH-1:0] ST_MAX = (64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [ACC_WIDTH-1:0] ST_MIN = -ST_MAX - 64'sd1;
  localparam logic signed [ACC_WIDTH-1:0] PS_MAX = (64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1;
  localparam logic signed [ACC_WIDTH-1:0] PS_MIN = -PS_MAX - 64'sd1;

  typedef enum logic [1:0] {
    REG_TIME_STEP = 2'd0,
    REG_GRAV_X    = 2'd1,
    REG_GRAV_Y    = 2'd2,
    REG_GRAV_Z    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [63:0]        time_tag;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
  } sample_t;

  typedef struct packed {
    logic [63:0]                  out_tag;
    logic signed [31:0]           quat_w;
    logic signed [31:0]           quat_x;
    logic signed [31:0]           quat_y;
    logic signed [31:0]           quat_z;
    logic signed [POS_WIDTH-1:0]  pos_x;
    logic signed [POS_WIDTH-1:0]  pos_y;
    logic signed [POS_WIDTH-1:0]  pos_z;
  } result_t;

  typedef enum logic [4:0] {
    S_Q0, S_Q1, S_Q2, S_Q3,
    S_A0, S_A1, S_A2,
    S_T0, S_T1, S_T2,
    S_R0, S_R1, S_R2,
    S_W0, S_W1, S_W2,
    S_V0, S_V1, S_V2,
    S_H0, S_H1, S_H2,
    S_P0, S_P1, S_P2,
    S_DT, S_DTSQ, S_ZERO
  } src_t;

  typedef enum logic [4:0] {
    D_NONE,
    D_T0, D_T1, D_T2,
    D_W0, D_W1, D_W2,
    D_DTSQ,
    D_H0, D_H1, D_H2,
    D_N0, D_N1, D_N2, D_N3,
    D_V0, D_V1, D_V2,
    D_P0, D_P1, D_P2
  } dst_t;

  typedef enum logic [1:0] {
    SH_Q,
    SH_H,
    SH_32,
    SH_33
  } shift_t;

  typedef enum logic [1:0] {
    K_SAT32,
    K_SAT2X,
    K_SAT48,
    K_RAW32
  } sat_t;

  typedef struct packed {
    src_t       a;
    src_t       b;
    shift_t     sh;
    logic       neg;
    logic       first;
    src_t       base;
    logic       add_g;
    logic [1:0] g_idx;
    logic       last;
    dst_t       dst;
    sat_t       kind;
  } uop_t;

  localparam logic [PC_WIDTH-1:0] UOP_LAST = PC_WIDTH'(UOP_COUNT - 1);

  function automatic uop_t mk(src_t a, src_t b, shift_t sh, logic neg, logic first,
                              src_t base, logic add_g, logic [1:0] g_idx,
                              logic last, dst_t dst, sat_t kind);
    uop_t u;
    u.a = a;
    u.b = b;
    u.sh = sh;
    u.neg = neg;
    u.first = first;
    u.base = base;
    u.add_g = add_g;
    u.g_idx = g_idx;
    u.last = last;
    u.dst = dst;
    u.kind = kind;
    return u;
  endfunction

  // Product step program. A step with first set starts a new sum from its base;
  // a step with last set writes the sum, saturated unless raw, to its destination.
  function automatic uop_t uop_at(logic [PC_WIDTH-1:0] k);
    uop_t u;
    case (k)
      // t = 2 * (qv x a)
      6'd0:  u = mk(S_Q2, S_A2, SH_Q, 1'b0, 1'b1, S_ZERO, 1'b0, 2'd0, 1'b0, D_NONE, K_SAT2X);
      6'd1:  u = mk(S_Q3, S_A1, SH_Q, 1'b1, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b1, D_T0, K_SAT2X);
      6'd2:  u = mk(S_Q3, S_A0, SH_Q, 1'b0, 1'b1, S_ZERO, 1'b0, 2'd0, 1'b0, D_NONE, K_SAT2X);
      6'd3:  u = mk(S_Q1, S_A2, SH_Q, 1'b1, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b1, D_T1, K_SAT2X);
      6'd4:  u = mk(S_Q1, S_A1, SH_Q, 1'b0, 1'b1, S_ZERO, 1'b0, 2'd0, 1'b0, D_NONE, K_SAT2X);
      6'd5:  u = mk(S_Q2, S_A0, SH_Q, 1'b1, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b1, D_T2, K_SAT2X);
      // world accel = a + qw*t + qv x t + g
      6'd6:  u = mk(S_Q0, S_T0, SH_Q, 1'b0, 1'b1, S_A0, 1'b1, 2'd0, 1'b0, D_NONE, K_SAT32);
      6'd7:  u = mk(S_Q2, S_T2, SH_Q, 1'b0, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b0, D_NONE, K_SAT32);
      6'd8:  u = mk(S_Q3, S_T1, SH_Q, 1'b1, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b1, D_W0, K_SAT32);
      6'd9:  u = mk(S_Q0, S_T1, SH_Q, 1'b0, 1'b1, S_A1, 1'b1, 2'd1, 1'b0, D_NONE, K_SAT32);
      6'd10: u = mk(S_Q3, S_T0, SH_Q, 1'b0, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b0, D_NONE, K_SAT32);
      6'd11: u = mk(S_Q1, S_T2, SH_Q, 1'b1, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b1, D_W1, K_SAT32);
      6'd12: u = mk(S_Q0, S_T2, SH_Q, 1'b0, 1'b1, S_A2, 1'b1, 2'd2, 1'b0, D_NONE, K_SAT32);
      6'd13: u = mk(S_Q1, S_T1, SH_Q, 1'b0, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b0, D_NONE, K_SAT32);
      6'd14: u = mk(S_Q2, S_T0, SH_Q, 1'b1, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b1, D_W2, K_SAT32);
      // dt squared
      6'd15: u = mk(S_DT, S_DT, SH_32, 1'b0, 1'b1, S_ZERO, 1'b0, 2'd0, 1'b1, D_DTSQ, K_RAW32);
      // half angle increments
      6'd16: u = mk(S_R0, S_DT, SH_H, 1'b0, 1'b1, S_ZERO, 1'b0, 2'd0, 1'b1, D_H0, K_SAT32);
      6'd17: u = mk(S_R1, S_DT, SH_H, 1'b0, 1'b1, S_ZERO, 1'b0, 2'd0, 1'b1, D_H1, K_SAT32);
      6'd18: u = mk(S_R2, S_DT, SH_H, 1'b0, 1'b1, S_ZERO, 1'b0, 2'd0, 1'b1, D_H2, K_SAT32);
      // new quaternion
      6'd19: u = mk(S_Q1, S_H0, SH_Q, 1'b1, 1'b1, S_Q0, 1'b0, 2'd0, 1'b0, D_NONE, K_SAT32);
      6'd20: u = mk(S_Q2, S_H1, SH_Q, 1'b1, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b0, D_NONE, K_SAT32);
      6'd21: u = mk(S_Q3, S_H2, SH_Q, 1'b1, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b1, D_N0, K_SAT32);
      6'd22: u = mk(S_Q0, S_H0, SH_Q, 1'b0, 1'b1, S_Q1, 1'b0, 2'd0, 1'b0, D_NONE, K_SAT32);
      6'd23: u = mk(S_Q2, S_H2, SH_Q, 1'b0, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b0, D_NONE, K_SAT32);
      6'd24: u = mk(S_Q3, S_H1, SH_Q, 1'b1, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b1, D_N1, K_SAT32);
      6'd25: u = mk(S_Q0, S_H1, SH_Q, 1'b0, 1'b1, S_Q2, 1'b0, 2'd0, 1'b0, D_NONE, K_SAT32);
      6'd26: u = mk(S_Q3, S_H0, SH_Q, 1'b0, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b0, D_NONE, K_SAT32);
      6'd27: u = mk(S_Q1, S_H2, SH_Q, 1'b1, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b1, D_N2, K_SAT32);
      6'd28: u = mk(S_Q0, S_H2, SH_Q, 1'b0, 1'b1, S_Q3, 1'b0, 2'd0, 1'b0, D_NONE, K_SAT32);
      6'd29: u = mk(S_Q1, S_H1, SH_Q, 1'b0, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b0, D_NONE, K_SAT32);
      6'd30: u = mk(S_Q2, S_H0, SH_Q, 1'b1, 1'b0, S_ZERO, 1'b0, 2'd0, 1'b1, D_N3, K_SAT32);
      // velocity, then position from the new velocity
      6'd31: u = mk(S_W0, S_DT, SH_32, 1'b0, 1'b1, S_V0, 1'b0, 2'd0, 1'b1, D_V0, K_SAT48);
      6'd32: u = mk(S_V0, S_DT, SH_32, 1'b0, 1'b1, S_P0, 1'b0, 2'd0, 1'b1, D_P0, K_SAT48);
      6'd33: u = mk(S_W0, S_DTSQ, SH_33, 1'b0, 1'b1, S_P0, 1'b0, 2'd0, 1'b1, D_P0, K_SAT48);
      6'd34: u = mk(S_W1, S_DT, SH_32, 1'b0, 1'b1, S_V1, 1'b0, 2'd0, 1'b1, D_V1, K_SAT48);
      6'd35: u = mk(S_V1, S_DT, SH_32, 1'b0, 1'b1, S_P1, 1'b0, 2'd0, 1'b1, D_P1, K_SAT48);
      6'd36: u = mk(S_W1, S_DTSQ, SH_33, 1'b0, 1'b1, S_P1, 1'b0, 2'd0, 1'b1, D_P1, K_SAT48);
      6'd37: u = mk(S_W2, S_DT, SH_32, 1'b0, 1'b1, S_V2, 1'b0, 2'd0, 1'b1, D_V2, K_SAT48);
      6'd38: u = mk(S_V2, S_DT, SH_32, 1'b0, 1'b1, S_P2, 1'b0, 2'd0, 1'b1, D_P2, K_SAT48);
      6'd39: u = mk(S_W2, S_DTSQ, SH_33, 1'b0, 1'b1, S_P2, 1'b0, 2'd0, 1'b1, D_P2, K_SAT48);
      default: u = mk(S_ZERO, S_ZERO, SH_Q, 1'b0, 1'b1, S_ZERO, 1'b0, 2'd0, 1'b0, D_NONE,
                      K_SAT32);
    endcase
    return u;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [ACC_WIDTH-1:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [STATE_WIDTH-1:0] sat_st(logic signed [ACC_WIDTH-1:0] x);
    logic signed [STATE_WIDTH-1:0] r;
    if (x > ST_MAX) begin
      r = ST_MAX[STATE_WIDTH-1:0];
    end else if (x < ST_MIN) begin
      r = ST_MIN[STATE_WIDTH-1:0];
    end else begin
      r = x[STATE_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [POS_WIDTH-1:0] sat_pos(logic signed [STATE_WIDTH-1:0] v);
    logic signed [ACC_WIDTH-1:0] x;
    logic signed [POS_WIDTH-1:0] r;
    x = ACC_WIDTH'(v);
    if (x > PS_MAX) begin
      r = PS_MAX[POS_WIDTH-1:0];
    end else if (x < PS_MIN) begin
      r = PS_MIN[POS_WIDTH-1:0];
    end else begin
      r = x[POS_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

[sv/imu_euler_pose_integrator.sv]
// A result word follows once all products of the sample's update are done; no new
// sample is taken until that result is in the output register. The 40 products go
// one at a time through a 48 x 4 bit digit-serial multiplier (load, digit steps,
// round, accumulate), so it sets the rate whenever the output does not stall.
// Reset (rst, synchronous) restores the attitude to identity, velocity and position
// to zero, and the time step and gravity registers to their default values.
module imu_euler_pose_integrator import imuepi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  sample_t     sample,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_ACCUM = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  localparam logic [CNT_WIDTH-1:0] MUL_LAST = CNT_WIDTH'(MUL_STEPS - 1);

  state_t state;
  logic [PC_WIDTH-1:0] pc;
  logic [CNT_WIDTH-1:0] cnt;

  logic [31:0] time_step;
  logic signed [31:0] grav [3];

  logic signed [31:0] q [4];
  logic signed [31:0] nq [4];
  logic signed [31:0] t [3];
  logic signed [31:0] w [3];
  logic signed [31:0] h [3];
  logic signed [31:0] acc_in [3];
  logic signed [31:0] rate [3];
  logic signed [STATE_WIDTH-1:0] v [3];
  logic signed [STATE_WIDTH-1:0] p [3];
  logic [31:0] dtsq;
  logic [63:0] tag;

  logic [AMAG_WIDTH-1:0] am;
  logic [BMAG_WIDTH-1:0] bm;
  logic msign;
  logic [PROD_WIDTH-1:0] prod;
  logic signed [ACC_WIDTH-1:0] rnd;
  logic signed [ACC_WIDTH-1:0] acc;

  uop_t op;
  logic signed [OPND_WIDTH-1:0] srcv [SRC_COUNT];
  logic signed [OPND_WIDTH-1:0] aval;
  logic signed [OPND_WIDTH-1:0] bval;
  logic [AMAG_WIDTH+DIGIT_WIDTH-1:0] pp;
  logic [PROD_WIDTH-1:0] rsum;
  logic [PROD_WIDTH-1:0] rmag;
  logic signed [ACC_WIDTH-1:0] gsel;
  logic signed [ACC_WIDTH-1:0] base_v;
  logic signed [ACC_WIDTH-1:0] acc_next;
  logic signed [31:0] w32;
  logic signed [STATE_WIDTH-1:0] wst;
  logic cfg_wr;
  logic sample_take;
  logic result_load;

  assign op = uop_at(pc);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign sample_ready = (state == ST_IDLE);
  assign sample_take = sample_valid && sample_ready;
  assign result_load = (state == ST_DONE) && (!result_valid || result_ready);

  always_comb begin
    for (int k = 0; k < SRC_COUNT; k++) begin
      srcv[k] = '0;
    end
    for (int k = 0; k < 4; k++) begin
      srcv[int'(S_Q0) + k] = OPND_WIDTH'(q[k]);
    end
    for (int k = 0; k < 3; k++) begin
      srcv[int'(S_A0) + k] = OPND_WIDTH'(acc_in[k]);
      srcv[int'(S_T0) + k] = OPND_WIDTH'(t[k]);
      srcv[int'(S_R0) + k] = OPND_WIDTH'(rate[k]);
      srcv[int'(S_W0) + k] = OPND_WIDTH'(w[k]);
      srcv[int'(S_V0) + k] = OPND_WIDTH'(v[k]);
      srcv[int'(S_H0) + k] = OPND_WIDTH'(h[k]);
      srcv[int'(S_P0) + k] = OPND_WIDTH'(p[k]);
    end
    srcv[S_DT] = OPND_WIDTH'($signed({1'b0, time_step}));
    srcv[S_DTSQ] = OPND_WIDTH'($signed({1'b0, dtsq}));
  end

  assign aval = srcv[op.a];
  assign bval = srcv[op.b];
  assign pp = am * bm[BMAG_WIDTH-1 -: DIGIT_WIDTH];

  // Round to nearest, ties away from zero, on the magnitude.
  always_comb begin
    case (op.sh)
      SH_Q: begin
        rsum = prod + (PROD_WIDTH'(1) << (QUAT_FRAC_BITS - 1));
        rmag = rsum >> QUAT_FRAC_BITS;
      end
      SH_H: begin
        rsum = prod + (PROD_WIDTH'(1) << (48 - QUAT_FRAC_BITS));
        rmag = rsum >> (49 - QUAT_FRAC_BITS);
      end
      SH_32: begin
        rsum = prod + (PROD_WIDTH'(1) << 31);
        rmag = rsum >> 32;
      end
      SH_33: begin
        rsum = prod + (PROD_WIDTH'(1) << 32);
        rmag = rsum >> 33;
      end
      default: begin
        rsum = prod;
        rmag = prod;
      end
    endcase
  end

  always_comb begin
    case (op.g_idx)
      2'd0: gsel = ACC_WIDTH'(grav[0]);
      2'd1: gsel = ACC_WIDTH'(grav[1]);
      2'd2: gsel = ACC_WIDTH'(grav[2]);
      default: gsel = '0;
    endcase
    if (op.first) begin
      base_v = ACC_WIDTH'(srcv[op.base]) + (op.add_g ? gsel : '0);
    end else begin
      base_v = acc;
    end
    acc_next = base_v + rnd;
    case (op.kind)
      K_SAT32: w32 = sat32(acc_next);
      K_SAT2X: w32 = sat32(acc_next <<< 1);
      K_RAW32: w32 = acc_next[31:0];
      default: w32 = sat32(acc_next);
    endcase
    wst = sat_st(acc_next);
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_TIME_STEP: prdata = time_step;
      REG_GRAV_X: prdata = grav[0];
      REG_GRAV_Y: prdata = grav[1];
      REG_GRAV_Z: prdata = grav[2];
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= DT_RESET;
      grav[0] <= '0;
      grav[1] <= '0;
      grav[2] <= GZ_RESET;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_TIME_STEP: time_step <= pwdata;
        REG_GRAV_X: grav[0] <= pwdata;
        REG_GRAV_Y: grav[1] <= pwdata;
        REG_GRAV_Z: grav[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc <= '0;
      cnt <= '0;
      result_valid <= 1'b0;
      q[0] <= QUAT_ONE;
      q[1] <= '0;
      q[2] <= '0;
      q[3] <= '0;
      for (int k = 0; k < 3; k++) begin
        v[k] <= '0;
        p[k] <= '0;
      end
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample_take) begin
            tag <= sample.time_tag;
            acc_in[0] <= sample.accel_x;
            acc_in[1] <= sample.accel_y;
            acc_in[2] <= sample.accel_z;
            rate[0] <= sample.rate_x;
            rate[1] <= sample.rate_y;
            rate[2] <= sample.rate_z;
            pc <= '0;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          am <= aval[OPND_WIDTH-1] ? AMAG_WIDTH'(-aval) : AMAG_WIDTH'(aval);
          bm <= bval[OPND_WIDTH-1] ? BMAG_WIDTH'(-bval) : BMAG_WIDTH'(bval);
          msign <= aval[OPND_WIDTH-1] ^ bval[OPND_WIDTH-1] ^ op.neg;
          prod <= '0;
          cnt <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          // Most significant digit of the multiplier first.
          prod <= (prod << DIGIT_WIDTH) + PROD_WIDTH'(pp);
          bm <= bm << DIGIT_WIDTH;
          cnt <= cnt + 1'b1;
          if (cnt == MUL_LAST) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          rnd <= msign ? -ACC_WIDTH'(rmag) : ACC_WIDTH'(rmag);
          state <= ST_ACCUM;
        end
        ST_ACCUM: begin
          acc <= acc_next;
          if (op.last) begin
            case (op.dst)
              D_T0: t[0] <= w32;
              D_T1: t[1] <= w32;
              D_T2: t[2] <= w32;
              D_W0: w[0] <= w32;
              D_W1: w[1] <= w32;
              D_W2: w[2] <= w32;
              D_DTSQ: dtsq <= w32;
              D_H0: h[0] <= w32;
              D_H1: h[1] <= w32;
              D_H2: h[2] <= w32;
              D_N0: nq[0] <= w32;
              D_N1: nq[1] <= w32;
              D_N2: nq[2] <= w32;
              D_N3: nq[3] <= w32;
              D_V0: v[0] <= wst;
              D_V1: v[1] <= wst;
              D_V2: v[2] <= wst;
              D_P0: p[0] <= wst;
              D_P1: p[1] <= wst;
              D_P2: p[2] <= wst;
              default: ;
            endcase
          end
          if (pc == UOP_LAST) begin
            state <= ST_DONE;
          end else begin
            pc <= pc + 1'b1;
            state <= ST_LOAD;
          end
        end
        ST_DONE: begin
          if (result_load) begin
            for (int k = 0; k < 4; k++) begin
              q[k] <= nq[k];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.out_tag <= tag;
      result.quat_w <= nq[0];
      result.quat_x <= nq[1];
      result.quat_y <= nq[2];
      result.quat_z <= nq[3];
      result.pos_x <= sat_pos(p[0]);
      result.pos_y <= sat_pos(p[1]);
      result.pos_z <= sat_pos(p[2]);
    end
  end

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    sample_take |=> (state == ST_LOAD) && (pc == '0))
    else $error("accepted sample did not start the step program");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= UOP_LAST)
    else $error("step counter beyond program");

  a_mul_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) && (cnt == MUL_LAST) |=> (state == ST_ROUND))
    else $error("multiplier did not finish after its last digit");

  a_done_out: assert property (@(posedge clk) disable iff (rst)
    result_load |=> result_valid && (state == ST_IDLE))
    else $error("finished update did not reach the output register");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import imuepi_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int BLOCK_LATENCY = 450;

  logic        clk;
  logic        rst;
  logic        sample_valid;
  logic        sample_ready;
  sample_t     sample;
  logic        result_valid;
  logic        result_ready;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  imu_euler_pose_integrator DUT (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the block's registers and navigation state.
  longint  nav_dt;
  longint  nav_grav[3];
  longint  nav_quat[4];
  longint  nav_vel[3];
  longint  nav_pos[3];
  result_t pose_queue[$];

  int errors;
  int samples_sent;
  int poses_checked;
  int sat_poses;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint round_shift(logic signed [127:0] x, int s);
    logic [127:0] m;
    logic         neg;
    neg = x < 0;
    m = neg ? -x : x;
    m = (m + (128'd1 << (s - 1))) >> s;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint mul_round(longint a, longint b, int s);
    logic signed [127:0] pa;
    logic signed [127:0] pb;
    pa = a;
    pb = b;
    return round_shift(pa * pb, s);
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint clamp32(longint x);
    return clamp(x, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint clamp_state(longint x);
    return clamp(x, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
  endfunction

  function automatic void cross_q(input longint u[3], input longint v[3],
                                  output longint c[3]);
    c[0] = mul_round(u[1], v[2], QUAT_FRAC_BITS) - mul_round(u[2], v[1], QUAT_FRAC_BITS);
    c[1] = mul_round(u[2], v[0], QUAT_FRAC_BITS) - mul_round(u[0], v[2], QUAT_FRAC_BITS);
    c[2] = mul_round(u[0], v[1], QUAT_FRAC_BITS) - mul_round(u[1], v[0], QUAT_FRAC_BITS);
  endfunction

  // Integrates one sample into the shadow state and returns the expected pose.
  function automatic result_t integrate_sample(sample_t s);
    longint  acc[3];
    longint  rate[3];
    longint  qv[3];
    longint  tv[3];
    longint  cv[3];
    longint  aw[3];
    longint  half[3];
    longint  nq[4];
    longint  qw;
    longint  dtsq;
    result_t r;
    acc[0] = s.accel_x;
    acc[1] = s.accel_y;
    acc[2] = s.accel_z;
    rate[0] = s.rate_x;
    rate[1] = s.rate_y;
    rate[2] = s.rate_z;
    qw = nav_quat[0];
    for (int i = 0; i < 3; i++) qv[i] = nav_quat[i + 1];
    dtsq = mul_round(nav_dt, nav_dt, 32);

    cross_q(qv, acc, tv);
    for (int i = 0; i < 3; i++) tv[i] = clamp32(2 * tv[i]);
    cross_q(qv, tv, cv);
    for (int i = 0; i < 3; i++)
      aw[i] = clamp32(acc[i] + mul_round(qw, tv[i], QUAT_FRAC_BITS) + cv[i] + nav_grav[i]);

    for (int i = 0; i < 3; i++)
      half[i] = clamp32(mul_round(rate[i], nav_dt, 49 - QUAT_FRAC_BITS));
    nq[0] = clamp32(qw - mul_round(qv[0], half[0], QUAT_FRAC_BITS)
                       - mul_round(qv[1], half[1], QUAT_FRAC_BITS)
                       - mul_round(qv[2], half[2], QUAT_FRAC_BITS));
    cross_q(qv, half, cv);
    for (int i = 0; i < 3; i++)
      nq[i + 1] = clamp32(qv[i] + mul_round(qw, half[i], QUAT_FRAC_BITS) + cv[i]);
    for (int i = 0; i < 4; i++) nav_quat[i] = nq[i];

    for (int i = 0; i < 3; i++) begin
      nav_vel[i] = clamp_state(nav_vel[i] + mul_round(aw[i], nav_dt, 32));
      nav_pos[i] = clamp_state(nav_pos[i] + mul_round(nav_vel[i], nav_dt, 32));
      nav_pos[i] = clamp_state(nav_pos[i] + mul_round(aw[i], dtsq, 33));
    end

    r.out_tag = s.time_tag;
    r.quat_w = nq[0][31:0];
    r.quat_x = nq[1][31:0];
    r.quat_y = nq[2][31:0];
    r.quat_z = nq[3][31:0];
    r.pos_x = nav_pos[0][47:0];
    r.pos_y = nav_pos[1][47:0];
    r.pos_z = nav_pos[2][47:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("%0t: pose %0d field %s got %h expected %h", $time, poses_checked, field,
             got, want);
  endtask

  // Sender and receiver handshakes both count as progress for the watchdog.
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout with %0d poses outstanding", pose_queue.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pose_queue.size() == 0) begin
        report_mismatch("unexpected out_tag", result.out_tag, 64'd0);
      end else begin
        want = pose_queue.pop_front();
        if (result.out_tag !== want.out_tag) report_mismatch("out_tag", result.out_tag, want.out_tag);
        if (result.quat_w !== want.quat_w) report_mismatch("quat_w", result.quat_w, want.quat_w);
        if (result.quat_x !== want.quat_x) report_mismatch("quat_x", result.quat_x, want.quat_x);
        if (result.quat_y !== want.quat_y) report_mismatch("quat_y", result.quat_y, want.quat_y);
        if (result.quat_z !== want.quat_z) report_mismatch("quat_z", result.quat_z, want.quat_z);
        if (result.pos_x !== want.pos_x) report_mismatch("pos_x", result.pos_x, want.pos_x);
        if (result.pos_y !== want.pos_y) report_mismatch("pos_y", result.pos_y, want.pos_y);
        if (result.pos_z !== want.pos_z) report_mismatch("pos_z", result.pos_z, want.pos_z);
        if (want.quat_w == 32'sh7FFF_FFFF || want.quat_w == 32'sh8000_0000) sat_poses++;
        poses_checked++;
      end
    end
  end

  task automatic send_sample(sample_t s);
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!sample_ready);
    pose_queue.insert(pose_queue.size(), integrate_sample(s));
    samples_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Lets the block finish its pending work so that registers may change.
  task automatic wait_idle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_TIME_STEP) begin
      nav_dt = longint'({32'b0, value});
    end else begin
      nav_grav[int'(idx) - 1] = longint'(signed'(value));
    end
  endtask

  task automatic set_config(logic [31:0] dt, logic [31:0] gx, logic [31:0] gy,
                            logic [31:0] gz);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_GRAV_X, gx);
    write_reg(REG_GRAV_Y, gy);
    write_reg(REG_GRAV_Z, gz);
  endtask

  function automatic sample_t make_sample(logic [63:0] tag, logic [31:0] ax, logic [31:0] ay,
                                          logic [31:0] az, logic [31:0] rx, logic [31:0] ry,
                                          logic [31:0] rz);
    sample_t s;
    s.time_tag = tag;
    s.accel_x = ax;
    s.accel_y = ay;
    s.accel_z = az;
    s.rate_x = rx;
    s.rate_y = ry;
    s.rate_z = rz;
    return s;
  endfunction

  // Mostly physically plausible motion, with a share of full-range words.
  function automatic logic [31:0] pick_value(int span);
    if ($urandom_range(99) < 25) return $urandom;
    return 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic sample_t random_sample();
    return make_sample({$urandom, $urandom}, pick_value(1500000), pick_value(1500000),
                       pick_value(1500000), pick_value(400000), pick_value(400000),
                       pick_value(400000));
  endfunction

  task automatic test_default_config();
    send_sample(make_sample(64'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    send_sample(make_sample(64'hFFFF_FFFF_FFFF_FFFF, 32'sd642908, 32'd0, 32'd0,
                            32'sd65536, 32'd0, 32'd0));
    send_sample(make_sample(64'h0123_4567_89AB_CDEF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_sample(make_sample(64'hFEDC_BA98_7654_3210, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_sample(make_sample(64'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    wait_idle();
  endtask

  task automatic test_register_extremes();
    // A zero time step must leave attitude, velocity and position untouched.
    set_config(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    send_sample(random_sample());
    send_sample(make_sample(64'd2, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'h8000_0000, 32'd0,
                            32'd0));
    wait_idle();
    set_config(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int i = 0; i < 6; i++) send_sample(random_sample());
    send_sample(make_sample(64'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    wait_idle();
    set_config(32'd1, 32'd0, 32'd0, 32'h8000_0000);
    for (int i = 0; i < 4; i++) send_sample(random_sample());
    wait_idle();
  endtask

  task automatic test_random_motion(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_config($urandom_range(1000000, 80000000), pick_value(700000), pick_value(700000),
               pick_value(700000));
    for (int i = 0; i < count; i++) begin
      send_sample(random_sample());
      if (i == count / 2) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    samples_sent = 0;
    send_idle_pct = 9;
    recv_idle_pct = 63;
    nav_dt = 20452225;
    nav_grav = '{0, 0, -642908};
    nav_quat = '{longint'(1) <<< QUAT_FRAC_BITS, 0, 0, 0};
    nav_vel = '{0, 0, 0};
    nav_pos = '{0, 0, 0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_config();
    test_register_extremes();
    test_random_motion(600, 9, 63);
    test_random_motion(600, 63, 9);
    test_random_motion(600, 0, 0);

    sample_valid <= 1'b0;
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (BLOCK_LATENCY) @(posedge clk);

    $display("Integrated %0d IMU samples and checked %0d poses (%0d with saturated qw),",
             samples_sent, poses_checked, sat_poses);
    $display("over default, zero, minimum and maximum time steps and gravity extremes.");
    if (errors == 0 && pose_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d poses never arrived", errors, pose_queue.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
